### rtl/modular_exponentiation_defines.svh
// Assertion helpers used by the top-level RTL.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MEXP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mexp_pkg.sv
`timescale 1ns / 1ps
package mexp_pkg;
    localparam int MOD_BITS  = 32;
    localparam int EXP_BITS  = 32;
    localparam int BASE_BITS = 64;
    localparam int OUT_BITS  = 32;
    localparam int CFG_BITS  = 32;
    // one extra cell holds the doubled remainder
    localparam int CELLS     = MOD_BITS + 1;
    localparam int CNT_BITS  = $clog2(BASE_BITS + 1);

    // register indexes
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic clear;
        logic step;
    } t_cell_ctl;
endpackage

### rtl/mexp_cell.sv
`timescale 1ns / 1ps
// One bit slice of the remainder: double, reduce, add, reduce.
module mexp_cell (
    input  logic                i_clk,
    input  mexp_pkg::t_cell_ctl i_ctl,
    input  logic                i_sh,
    input  logic                i_nb,
    input  logic                i_ab,
    input  logic                i_b1,
    input  logic                i_c2,
    input  logic                i_b3,
    input  logic                i_sel1,
    input  logic                i_sel3,
    output logic                o_b1,
    output logic                o_c2,
    output logic                o_b3,
    output logic                o_r
);
    logic r_bit;
    logic n_bit;
    logic d1, ub, v, w;

    // 2r - n
    assign d1   = i_sh ^ i_nb ^ i_b1;
    assign o_b1 = (~i_sh & (i_nb | i_b1)) | (i_nb & i_b1);
    assign ub   = i_sel1 ? d1 : i_sh;
    // + addend
    assign v    = ub ^ i_ab ^ i_c2;
    assign o_c2 = (ub & i_ab) | (ub & i_c2) | (i_ab & i_c2);
    // - n
    assign w    = v ^ i_nb ^ i_b3;
    assign o_b3 = (~v & (i_nb | i_b3)) | (i_nb & i_b3);

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.clear) begin
            n_bit = 1'b0;
        end else if (i_ctl.step) begin
            n_bit = i_sel3 ? w : v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit <= n_bit;
    end

    assign o_r = r_bit;
endmodule

### rtl/mexp_chain.sv
`timescale 1ns / 1ps
// Row of remainder cells; one step computes r = ((2r + s) mod n + a) mod n.
module mexp_chain (
    input  logic                          i_clk,
    input  mexp_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_shift_in,
    input  logic [mexp_pkg::MOD_BITS-1:0] i_mod,
    input  logic [mexp_pkg::MOD_BITS-1:0] i_addend,
    output logic [mexp_pkg::CELLS-1:0]    o_rem
);
    logic [mexp_pkg::CELLS:0]   b1, c2, b3;
    logic [mexp_pkg::CELLS-1:0] sh, nb, ab;
    logic sel1, sel3;

    assign b1[0] = 1'b0;
    assign c2[0] = 1'b0;
    assign b3[0] = 1'b0;
    assign sh    = {o_rem[mexp_pkg::CELLS-2:0], i_shift_in};
    assign nb    = {1'b0, i_mod};
    assign ab    = {1'b0, i_addend};
    // no borrow out of the top means the difference is kept
    assign sel1  = ~b1[mexp_pkg::CELLS];
    assign sel3  = ~b3[mexp_pkg::CELLS];

    for (genvar j = 0; j < mexp_pkg::CELLS; j++) begin : g_cell
        mexp_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_sh   (sh[j]),
            .i_nb   (nb[j]),
            .i_ab   (ab[j]),
            .i_b1   (b1[j]),
            .i_c2   (c2[j]),
            .i_b3   (b3[j]),
            .i_sel1 (sel1),
            .i_sel3 (sel3),
            .o_b1   (b1[j+1]),
            .o_c2   (c2[j+1]),
            .o_b3   (b3[j+1]),
            .o_r    (o_rem[j])
        );
    end
endmodule

### rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// Modular exponentiation, base^exponent mod modulus, right-to-left square and
// multiply. One item at a time: the 64-bit base is first reduced, one base bit
// per step, then each exponent bit costs a multiply pass when set plus a
// squaring pass (skipped after the top set bit), with a decision state after
// each pass through the cell row. All work runs through one row of bit-slice
// cells doing one shift-add-reduce per cycle.
// A zero exponent gives 1 and a zero modulus gives 0 without using the cell row.
// The next base is taken while a finished result still waits on the output.
`include "modular_exponentiation_defines.svh"
module modular_exponentiation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] base_value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] power_result
);
    localparam int W = mexp_pkg::MOD_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_NEXT = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [1:0] K_RED = 2'd0;
    localparam logic [1:0] K_ACC = 2'd1;
    localparam logic [1:0] K_SQ  = 2'd2;

    logic [mexp_pkg::EXP_BITS-1:0]  r_exp_cfg, n_exp_cfg;
    logic [W-1:0]                   r_mod, n_mod;
    logic [1:0]                     r_state, n_state;
    logic [1:0]                     r_kind, n_kind;
    logic [mexp_pkg::CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [mexp_pkg::BASE_BITS-1:0] r_base, n_base;
    logic [mexp_pkg::EXP_BITS-1:0]  r_exp, n_exp;
    logic [W-1:0]                   r_acc, n_acc, r_sq, n_sq;
    logic [W-1:0]                   r_mb, n_mb, r_res, n_res, r_out, n_out;
    logic                           r_ov, n_ov;

    mexp_pkg::t_cell_ctl     ctl;
    logic                    shift_in;
    logic [W-1:0]            addend;
    logic [mexp_pkg::CELLS-1:0] rem;
    logic [W-1:0]            rem_w;
    logic                    s_xfer, m_xfer;

    assign s_xfer = i_s_tvalid && o_s_tready;
    assign m_xfer = o_m_tvalid && i_m_tready;
    assign rem_w  = rem[W-1:0];

    mexp_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_shift_in (shift_in),
        .i_mod      (r_mod),
        .i_addend   (addend),
        .o_rem      (rem)
    );

    // configuration writes
    always_comb begin
        n_exp_cfg = r_exp_cfg;
        n_mod     = r_mod;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mexp_pkg::REG_EXPONENT: n_exp_cfg = i_cfg_data;
                mexp_pkg::REG_MODULUS:  n_mod     = i_cfg_data[W-1:0];
                default:                n_mod     = r_mod;
            endcase
        end
    end

    // sequencer
    always_comb begin
        logic [W-1:0] acc_v, sq_v;
        logic [mexp_pkg::EXP_BITS-1:0] e_v;
        n_state  = r_state;
        n_kind   = r_kind;
        n_cnt    = r_cnt;
        n_base   = r_base;
        n_exp    = r_exp;
        n_acc    = r_acc;
        n_sq     = r_sq;
        n_mb     = r_mb;
        n_res    = r_res;
        n_out    = r_out;
        n_ov     = r_ov && !m_xfer;
        ctl      = '0;
        shift_in = 1'b0;
        addend   = '0;
        acc_v    = r_acc;
        sq_v     = r_sq;
        e_v      = r_exp;
        unique case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_base = i_s_tdata;
                    n_exp  = r_exp_cfg;
                    n_acc  = W'(1);
                    if (r_exp_cfg == '0) begin
                        n_res   = W'(1);
                        n_state = S_FIN;
                    end else if (r_mod == '0) begin
                        n_res   = '0;
                        n_state = S_FIN;
                    end else begin
                        ctl.clear = 1'b1;
                        n_kind    = K_RED;
                        n_cnt     = mexp_pkg::CNT_BITS'(mexp_pkg::BASE_BITS);
                        n_state   = S_RUN;
                    end
                end
            end
            S_RUN: begin
                ctl.step = 1'b1;
                if (r_kind == K_RED) begin
                    shift_in = r_base[mexp_pkg::BASE_BITS-1];
                    n_base   = r_base << 1;
                end else begin
                    addend = r_mb[W-1] ? r_sq : '0;
                    n_mb   = r_mb << 1;
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == mexp_pkg::CNT_BITS'(1)) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                // collect the pass result, then pick the next pass
                unique case (r_kind)
                    K_ACC:   acc_v = rem_w;
                    K_SQ: begin
                        sq_v = rem_w;
                        e_v  = r_exp >> 1;
                    end
                    default: sq_v = rem_w;
                endcase
                n_acc = acc_v;
                n_sq  = sq_v;
                n_exp = e_v;
                ctl.clear = 1'b1;
                n_cnt = mexp_pkg::CNT_BITS'(W);
                if (e_v[0] && r_kind != K_ACC) begin
                    n_kind  = K_ACC;
                    n_mb    = acc_v;
                    n_state = S_RUN;
                end else if ((e_v >> 1) == '0) begin
                    n_res   = acc_v;
                    n_state = S_FIN;
                end else begin
                    n_kind  = K_SQ;
                    n_mb    = sq_v;
                    n_state = S_RUN;
                end
            end
            default: begin
                if (!r_ov || i_m_tready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ov      <= 1'b0;
            r_exp_cfg <= '0;
            r_mod     <= W'(1);
        end else begin
            r_state   <= n_state;
            r_ov      <= n_ov;
            r_exp_cfg <= n_exp_cfg;
            r_mod     <= n_mod;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_cnt  <= n_cnt;
        r_base <= n_base;
        r_exp  <= n_exp;
        r_acc  <= n_acc;
        r_sq   <= n_sq;
        r_mb   <= n_mb;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = mexp_pkg::OUT_BITS'(r_out);

    // remainder stays reduced while the cell row works
    `MEXP_ASSERT_NOW(a_rem_reduced, r_state == S_RUN || r_state == S_NEXT, rem < {1'b0, r_mod}, "remainder not reduced")
    // nonzero exponent with nonzero modulus gives a reduced result
    `MEXP_ASSERT_NOW(a_res_reduced, r_state == S_FIN && r_exp != '0 && r_mod != '0, r_res < r_mod, "result not reduced")
    // zero exponent goes straight to the output stage
    `MEXP_ASSERT_NEXT(a_zero_exp, s_xfer && r_exp_cfg == '0, r_state == S_FIN && r_res == W'(1), "zero exponent path")
endmodule
